FILE: rtl/sha256_byte_stream_hasher_top_macros.svh
// assertion helpers shared by the hasher rtl
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SBH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SBH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sbh_pkg.sv
`default_nettype none

package sbh_pkg;

  localparam int unsigned SBH_WORD_W      = 32;
  localparam int unsigned SBH_HASH_DEPTH  = 8;
  localparam int unsigned SBH_BLOCK_DEPTH = 16;
  localparam int unsigned SBH_COUNT_W     = 61;
  localparam logic [7:0]  SBH_PAD_BYTE    = 8'h80;

  typedef logic [SBH_WORD_W-1:0] word_t;

  // round constants
  localparam word_t SBH_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial hash value
  localparam word_t SBH_IV [0:SBH_HASH_DEPTH-1] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // control from the sequencer to the compression datapath
  typedef struct packed {
    logic       load;   // shift a hash word into the working set
    logic       round;  // run one compression round
    logic       drain;  // shift the working set out toward the hash update
    logic       mem_w;  // round word comes from the block memory
    logic [5:0] rnd;    // round number
  } cmp_ctl_t;

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (SBH_WORD_W - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sbh_ifs.sv
`default_nettype none

// byte stream channel
interface sbh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

// digest word channel
interface sbh_out_if;
  logic                valid;
  logic                ready;
  sbh_pkg::word_t      digest_word;
  logic [2:0]          word_index;
  logic                last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

FILE: rtl/sbh_ram.sv
`default_nettype none

module sbh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/sbh_compress.sv
`default_nettype none

module sbh_compress (
  input  wire logic              clk,
  input  wire sbh_pkg::cmp_ctl_t ctl,
  input  wire sbh_pkg::word_t    load_word,
  input  wire sbh_pkg::word_t    mem_word,
  output sbh_pkg::word_t         head_word
);

  sbh_pkg::word_t v_r   [0:7];
  sbh_pkg::word_t v_nxt [0:7];
  sbh_pkg::word_t s_r   [0:15];
  sbh_pkg::word_t s_nxt [0:15];
  sbh_pkg::word_t wn_r;
  sbh_pkg::word_t wn_nxt;
  sbh_pkg::word_t w_cur;
  sbh_pkg::word_t t1;
  sbh_pkg::word_t t2;
  sbh_pkg::word_t ch;
  sbh_pkg::word_t maj;

  // round datapath and schedule expansion one round ahead
  always_comb begin
    w_cur  = ctl.mem_w ? mem_word : wn_r;
    ch     = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj    = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1     = v_r[7] + sbh_pkg::big_sigma1(v_r[4]) + ch + sbh_pkg::SBH_K[ctl.rnd] + w_cur;
    t2     = sbh_pkg::big_sigma0(v_r[0]) + maj;
    wn_nxt = s_r[1] + sbh_pkg::small_sigma0(s_r[2]) + s_r[10]
             + sbh_pkg::small_sigma1(s_r[15]);

    for (int j = 0; j < 8; j++) begin
      v_nxt[j] = v_r[j];
    end
    for (int j = 0; j < 16; j++) begin
      s_nxt[j] = s_r[j];
    end

    if (ctl.load || ctl.drain) begin
      for (int j = 0; j < 7; j++) begin
        v_nxt[j] = v_r[j+1];
      end
      v_nxt[7] = ctl.load ? load_word : v_r[7];
    end else if (ctl.round) begin
      v_nxt[0] = t1 + t2;
      v_nxt[1] = v_r[0];
      v_nxt[2] = v_r[1];
      v_nxt[3] = v_r[2];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[5] = v_r[4];
      v_nxt[6] = v_r[5];
      v_nxt[7] = v_r[6];
      for (int j = 0; j < 15; j++) begin
        s_nxt[j] = s_r[j+1];
      end
      s_nxt[15] = w_cur;
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk) begin
    for (int j = 0; j < 8; j++) begin
      v_r[j] <= v_nxt[j];
    end
    for (int j = 0; j < 16; j++) begin
      s_r[j] <= s_nxt[j];
    end
    if (ctl.round) begin
      wn_r <= wn_nxt;
    end
  end

  assign head_word = v_r[0];

endmodule

`default_nettype wire

FILE: rtl/sha256_byte_stream_hasher_top.sv
// Accepts one byte transaction per cycle while a block fills; the 64th byte of a
// block stalls the input during the 8-word hash load, 64 rounds and 8-word update.
// End of message: one padding byte per cycle (9 to 72) save during compression,
// one or two compressions, then eight digest words, each held until the sink is ready.
// Synchronous active-low reset: idle, empty block, zero count, hash reads as the IV
// through a flag, so no memory clearing pass is needed.
`default_nettype none

`include "sha256_byte_stream_hasher_top_macros.svh"

module sha256_byte_stream_hasher_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sbh_in_if.sink     in_chan,
  sbh_out_if.source  out_chan
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HLOAD = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_HUPD  = 3'd3;
  localparam logic [2:0] S_PAD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int unsigned HAW = $clog2(sbh_pkg::SBH_HASH_DEPTH);
  localparam int unsigned BAW = $clog2(sbh_pkg::SBH_BLOCK_DEPTH);

  logic [2:0]                      state_r,       state_nxt;
  logic [5:0]                      fill_r,        fill_nxt;
  logic [sbh_pkg::SBH_COUNT_W-1:0] count_r,       count_nxt;
  logic [63:0]                     len_r,         len_nxt;
  logic [23:0]                     acc_r,         acc_nxt;
  logic                            pad_active_r,  pad_active_nxt;
  logic                            pad_first_r,   pad_first_nxt;
  logic                            len_phase_r,   len_phase_nxt;
  logic                            final_r,       final_nxt;
  logic                            hinit_r,       hinit_nxt;
  logic [3:0]                      cnt_r,         cnt_nxt;
  logic [5:0]                      rnd_r,         rnd_nxt;
  logic                            out_valid_r,   out_valid_nxt;
  logic                            rd_pend_r,     rd_pend_nxt;
  logic [2:0]                      out_idx_r,     out_idx_nxt;
  sbh_pkg::word_t                  out_word_r,    out_word_nxt;
  logic [HAW-1:0]                  haddr_q_r;

  logic                            in_accept;
  logic                            push_en;
  logic [7:0]                      push_byte;
  logic                            block_full;
  logic                            len_sel;
  logic [2:0]                      len_idx;
  logic [7:0]                      len_byte;
  logic [3:0]                      cnt_dec;

  logic                            h_we;
  logic [HAW-1:0]                  h_waddr;
  sbh_pkg::word_t                  h_wdata;
  logic [HAW-1:0]                  h_raddr;
  sbh_pkg::word_t                  h_rdata;
  sbh_pkg::word_t                  h_eff;

  logic                            b_we;
  logic [BAW-1:0]                  b_waddr;
  sbh_pkg::word_t                  b_wdata;
  logic [BAW-1:0]                  b_raddr;
  sbh_pkg::word_t                  b_rdata;

  sbh_pkg::cmp_ctl_t               cmp_ctl;
  sbh_pkg::word_t                  head_word;

  // memories: running hash and current block
  sbh_ram #(
    .WIDTH (sbh_pkg::SBH_WORD_W),
    .DEPTH (sbh_pkg::SBH_HASH_DEPTH)
  ) u_hash_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  sbh_ram #(
    .WIDTH (sbh_pkg::SBH_WORD_W),
    .DEPTH (sbh_pkg::SBH_BLOCK_DEPTH)
  ) u_block_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  sbh_compress u_compress (
    .clk       (clk),
    .ctl       (cmp_ctl),
    .load_word (h_eff),
    .mem_word  (b_rdata),
    .head_word (head_word)
  );

  // hash reads return the IV after reset or a digest, until the next hash update
  assign h_eff = hinit_r ? sbh_pkg::SBH_IV[haddr_q_r] : h_rdata;

  assign in_accept = in_chan.valid && in_chan.ready;

  // length byte for the tail of the final block
  assign len_idx  = 3'd7 - fill_r[2:0];
  assign len_byte = len_r[{len_idx, 3'b000} +: 8];
  assign len_sel  = !pad_first_r && (len_phase_r || fill_r == 6'd56);
  assign cnt_dec  = cnt_r - 4'd1;

  // byte packing into block words
  assign block_full = push_en && (fill_r == 6'd63);
  assign b_we       = push_en && (fill_r[1:0] == 2'b11);
  assign b_waddr    = fill_r[5:2];
  assign b_wdata    = {acc_r, push_byte};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    count_nxt      = count_r;
    len_nxt        = len_r;
    acc_nxt        = acc_r;
    pad_active_nxt = pad_active_r;
    pad_first_nxt  = pad_first_r;
    len_phase_nxt  = len_phase_r;
    final_nxt      = final_r;
    hinit_nxt      = hinit_r;
    cnt_nxt        = cnt_r;
    rnd_nxt        = rnd_r;
    out_valid_nxt  = out_valid_r;
    rd_pend_nxt    = rd_pend_r;
    out_idx_nxt    = out_idx_r;
    out_word_nxt   = out_word_r;
    push_en        = 1'b0;
    push_byte      = 8'h00;
    h_we           = 1'b0;
    h_waddr        = cnt_dec[HAW-1:0];
    h_wdata        = h_eff + head_word;
    h_raddr        = cnt_r[HAW-1:0];
    b_raddr        = rnd_r[BAW-1:0] + BAW'(1);
    cmp_ctl        = '0;
    cmp_ctl.rnd    = rnd_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_chan.has_byte) begin
            push_en   = 1'b1;
            push_byte = in_chan.data_byte;
            count_nxt = count_r + sbh_pkg::SBH_COUNT_W'(1);
          end
          if (in_chan.end_of_message) begin
            pad_active_nxt = 1'b1;
            pad_first_nxt  = 1'b1;
            len_nxt        = {count_r + sbh_pkg::SBH_COUNT_W'(in_chan.has_byte), 3'b000};
            count_nxt      = '0;
          end
          if (block_full) begin
            state_nxt = S_HLOAD;
            cnt_nxt   = 4'd0;
          end else if (in_chan.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end

      S_PAD: begin
        push_en       = 1'b1;
        pad_first_nxt = 1'b0;
        if (pad_first_r) begin
          push_byte = sbh_pkg::SBH_PAD_BYTE;
        end else if (len_sel) begin
          push_byte = len_byte;
        end
        if (len_sel) begin
          len_phase_nxt = 1'b1;
        end
        if (block_full) begin
          final_nxt = len_sel;
          state_nxt = S_HLOAD;
          cnt_nxt   = 4'd0;
        end
      end

      S_HLOAD: begin
        cmp_ctl.load = (cnt_r != 4'd0);
        if (cnt_r == 4'd8) begin
          b_raddr   = '0;
          rnd_nxt   = 6'd0;
          state_nxt = S_ROUND;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end

      S_ROUND: begin
        cmp_ctl.round = 1'b1;
        cmp_ctl.mem_w = (rnd_r[5:4] == 2'b00);
        if (rnd_r == 6'd63) begin
          cnt_nxt   = 4'd0;
          state_nxt = S_HUPD;
        end else begin
          rnd_nxt = rnd_r + 6'd1;
        end
      end

      S_HUPD: begin
        if (cnt_r != 4'd0) begin
          h_we          = 1'b1;
          cmp_ctl.drain = 1'b1;
        end
        if (cnt_r == 4'd8) begin
          hinit_nxt = 1'b0;
          if (final_r) begin
            final_nxt      = 1'b0;
            pad_active_nxt = 1'b0;
            len_phase_nxt  = 1'b0;
            out_idx_nxt    = 3'd0;
            state_nxt      = S_OUT;
          end else if (pad_active_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end

      S_OUT: begin
        h_raddr = out_idx_r;
        if (!out_valid_r && !rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          out_word_nxt  = h_eff;
          out_valid_nxt = 1'b1;
          rd_pend_nxt   = 1'b0;
        end
        if (out_valid_r && out_chan.ready) begin
          out_valid_nxt = 1'b0;
          if (out_idx_r == 3'd7) begin
            out_idx_nxt = 3'd0;
            hinit_nxt   = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            out_idx_nxt = out_idx_r + 3'd1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // every byte push advances the fill and the word accumulator
    if (push_en) begin
      fill_nxt = fill_r + 6'd1;
      acc_nxt  = {acc_r[15:0], push_byte};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= 6'd0;
      count_r      <= '0;
      pad_active_r <= 1'b0;
      pad_first_r  <= 1'b0;
      len_phase_r  <= 1'b0;
      final_r      <= 1'b0;
      hinit_r      <= 1'b1;
      cnt_r        <= 4'd0;
      rnd_r        <= 6'd0;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_idx_r    <= 3'd0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      count_r      <= count_nxt;
      pad_active_r <= pad_active_nxt;
      pad_first_r  <= pad_first_nxt;
      len_phase_r  <= len_phase_nxt;
      final_r      <= final_nxt;
      hinit_r      <= hinit_nxt;
      cnt_r        <= cnt_nxt;
      rnd_r        <= rnd_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_idx_r    <= out_idx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    acc_r      <= acc_nxt;
    out_word_r <= out_word_nxt;
    haddr_q_r  <= h_raddr;
  end

  // channel ports
  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.digest_word = out_word_r;
  assign out_chan.word_index  = out_idx_r;
  assign out_chan.last_word   = (out_idx_r == 3'd7);

  // checks
  `SBH_ASSERT_SAME(a_out_only_in_out, out_valid_r, state_r == S_OUT, "digest word outside output phase")
  `SBH_ASSERT_SAME(a_compress_on_full, state_r == S_HLOAD, fill_r == 6'd0, "compression started on a partial block")
  `SBH_ASSERT_NEXT(a_rounds_to_update, state_r == S_ROUND && rnd_r == 6'd63, state_r == S_HUPD && cnt_r == 4'd0, "hash update did not follow last round")
  `SBH_ASSERT_NEXT(a_digest_done, out_valid_r && out_chan.ready && out_idx_r == 3'd7, state_r == S_IDLE && hinit_r && count_r == '0 && fill_r == 6'd0, "state not back to initial after digest")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 300;
  localparam int unsigned RANDOM_BYTES   = 130;
  localparam logic [7:0]  PAD_MARKER     = 8'h80;
  localparam int unsigned LENGTH_SLOT    = 56;

  localparam bit [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam bit [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  // running sha-256 state and the digest words still owed by the block
  class digest_scoreboard;
    bit [31:0]     chain [8];
    bit [31:0]     blk [16];
    int unsigned   fill;
    bit [60:0]     msg_len;
    digest_entry_t awaited [$];
    int unsigned   errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = START_HASH[i];
      fill = 0;
      msg_len = '0;
    endfunction

    function bit [31:0] rotr(bit [31:0] x, int unsigned n);
      bit [63:0] twice;
      twice = {x, x} >> n;
      return twice[31:0];
    endfunction

    // 64 rounds over the current block into the chaining value
    function void compress();
      bit [31:0] sched [64];
      bit [31:0] v [8];
      bit [31:0] s0, s1, t1, t2, choose, major;
      for (int i = 0; i < 16; i++) sched[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
        s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
        s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
        sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
      end
      foreach (v[i]) v[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
        choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
        major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + choose
             + ROUND_K[i] + sched[i];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + major;
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      foreach (chain[i]) chain[i] += v[i];
    endfunction

    // big-endian byte packing, a word is cleared on its first byte
    function void absorb(bit [7:0] b);
      if (fill[1:0] == 2'd0) blk[fill >> 2] = '0;
      blk[fill >> 2][(3 - fill[1:0]) * 8 +: 8] = b;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    function void note_input(bit [7:0] data_byte, bit has_byte, bit end_of_message);
      bit [63:0]     len_bits;
      digest_entry_t entry;
      if (has_byte) begin
        absorb(data_byte);
        msg_len++;
      end
      if (!end_of_message) return;
      // padding, zero fill and bit length, possibly spilling into an extra block
      len_bits = {msg_len, 3'b000};
      absorb(PAD_MARKER);
      while (fill != LENGTH_SLOT) absorb(8'h00);
      for (int i = 0; i < 8; i++) absorb(len_bits[63 - 8 * i -: 8]);
      for (int i = 0; i < 8; i++) begin
        entry.word  = chain[i];
        entry.index = 3'(i);
        entry.last  = (i == 7);
        awaited = {awaited, entry};
      end
      restart();
    endfunction

    function void check_result(logic [31:0] word, logic [2:0] index, logic last);
      digest_entry_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected digest word: expected none, actual %h index %0d last %b",
                 $time, word, index, last);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (word !== want.word) begin
        $display("%0t: digest_word mismatch: expected %h, actual %h", $time, want.word, word);
        errors++;
      end
      if (index !== want.index) begin
        $display("%0t: word_index mismatch: expected %0d, actual %0d",
                 $time, want.index, index);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_word mismatch: expected %b, actual %b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sbh_in_if  in_ch ();
  sbh_out_if out_ch ();

  sha256_byte_stream_hasher_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  digest_scoreboard board;
  int unsigned      idle_cycles;
  int unsigned      bytes_sent;
  bit               in_quiet;

  always #5 clk = ~clk;

  // monitor both channels and watch for a stalled run
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        board.note_input(in_ch.data_byte, in_ch.has_byte, in_ch.end_of_message);
      if (out_ch.valid && out_ch.ready)
        board.check_result(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // one input transaction, after a random gap
  task automatic send_item(input logic [7:0] data_byte, input logic has_byte,
                           input logic end_of_message);
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= data_byte;
    in_ch.has_byte       <= has_byte;
    in_ch.end_of_message <= end_of_message;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // a message of random bytes, with ignored filler and either style of ending
  task automatic send_message(input int unsigned len);
    bit split_end;
    split_end = (len == 0) || ($urandom_range(0, 2) == 0);
    in_quiet  = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !split_end);
      bytes_sent++;
    end
    if (split_end) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      bytes_sent++;
    end
  endtask

  // result side backpressure, with occasional runs of no stalls
  initial begin
    int unsigned gap;
    int unsigned quiet_left;
    quiet_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (quiet_left == 0 && $urandom_range(0, 7) == 0) quiet_left = 12;
      if (quiet_left > 0) begin
        gap = 0;
        quiet_left--;
      end else begin
        gap = $urandom_range(0, 6);
      end
      repeat (gap) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  initial begin
    int unsigned forced_len [2];
    int unsigned msg_count;
    int unsigned len;
    forced_len = '{56, 64};
    msg_count = 0;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.has_byte = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready = 1'b0;
    idle_cycles = 0;
    bytes_sent = 0;
    in_quiet = 1'b0;
    board = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle item, empty message, "abc", byte extremes, split endings
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h3c, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h5a, 1'b1, 1'b0);
    send_item(8'hc3, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b1);

    // random messages, first ones on the padding boundaries
    while (bytes_sent < RANDOM_BYTES) begin
      if (msg_count < 2) begin
        len = forced_len[msg_count];
      end else if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(0, 20);
      end else if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(119, 121);
      end else begin
        len = $urandom_range(55, 65);
      end
      send_message(len);
      msg_count++;
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // drain the digest words, then look for stray output
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
